// ===== hw/rtl/cabn_pkg.sv =====
// Shared types and field widths for the class-aware box suppression block.
// No dependencies; used by class_aware_box_nms.
package cabn_pkg;

    localparam int ScoreW = 16;
    localparam int ClassW = 8;
    localparam int CoordW = 14;
    localparam int SizeW  = 13;
    localparam int ThrW   = 9;
    localparam int BoxW   = ScoreW + ClassW + 2 * CoordW + 2 * SizeW;
    localparam int DataW  = ((BoxW + 7) / 8) * 8;
    localparam logic [ThrW-1:0] ThrReset = 9'd102;

    typedef struct packed {
        logic        [SizeW-1:0]  height;
        logic        [SizeW-1:0]  width;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] left;
        logic        [ClassW-1:0] class_id;
        logic        [ScoreW-1:0] score;
    } t_box;

endpackage

// ===== hw/rtl/class_aware_box_nms.sv =====
// Class-aware greedy non-maximum suppression over one set of detection boxes.
// Depends on cabn_pkg for the box record type and field widths.
//
// Usage: boxes arrive on the slave stream (s_tdata holds score, class, left,
// top, width, height from the lowest bit up; s_tlast marks the last box of a
// set). Each transfer is insertion-sorted into a single-port-read box memory
// in descending score order, equal scores kept in arrival order. Insertion
// walks from the tail towards the head, moving each lower-scored entry one
// place towards the tail. A box arriving with the memory full is dropped and
// the set is flagged. On the last box the block runs the greedy suppression
// pass: for every surviving box it reads each later entry through the memory
// read port and, for one of the same class not yet suppressed, evaluates the
// overlap test in a multiply chain (geometry, products, union, threshold
// product, compare). Survivors then leave on the master stream in score order,
// m_tlast on the last one, m_tuser carrying the overflow flag. A stall on
// m_tready simply holds the output register and the pass. s_tready is high
// only in the idle state: between insertions, never during an insertion,
// the suppression pass or the output pass. The threshold is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while idle, as the block
// does not enforce this. Reset clears the box count, suppression flags and
// overflow flag and loads the threshold 102; the box memory itself is not
// cleared, as only stored entries are read.
module class_aware_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cabn_pkg::ThrW-1:0]   i_cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // score, class_id, box_left, box_top, box_width, box_height (low bit up)
    input  logic [cabn_pkg::DataW-1:0]  s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // kept_score, kept_class, kept_left, kept_top, kept_width, kept_height
    output logic [cabn_pkg::DataW-1:0]  m_tdata,
    output logic                        m_tlast,
    // overflowed
    output logic                        m_tuser
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int CoordW = cabn_pkg::CoordW;
    localparam int SizeW  = cabn_pkg::SizeW;
    localparam int AreaW  = 2 * SizeW;

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_INS2, S_OI, S_LOADI, S_AREA, S_RDJ, S_GEOM,
        S_MUL, S_UNI, S_THR, S_CMP, S_ERD, S_EOUT, S_EWAIT
    } t_state;

    t_state r_state;

    // Box memory: one write port, one registered read port.
    cabn_pkg::t_box mem [MAX_BOXES];
    cabn_pkg::t_box r_rd;
    logic           rd_en, we;
    logic [AW-1:0]  rd_addr, wr_addr;
    cabn_pkg::t_box wr_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    logic [cabn_pkg::ThrW-1:0] r_thr;
    logic [CW-1:0]             r_count, r_k, r_i, r_j, r_last;
    logic [MAX_BOXES-1:0]      r_supp;
    logic                      r_ovf, r_item_last;
    cabn_pkg::t_box            r_item, r_bi;
    logic [AreaW-1:0]          r_area_a, r_area_b, r_inter;
    logic [SizeW:0]            r_dx, r_dy;
    logic [SizeW-1:0]          r_bw, r_bh;
    logic                      r_hit;
    logic [AreaW:0]            r_union;
    logic [AreaW+cabn_pkg::ThrW:0] r_prod;

    // Overlap extents of the held box and the box just read.
    logic signed [CoordW:0] ar, ab, br, bb, x0, y0, x1, y1;
    logic signed [CoordW+1:0] dx, dy;

    always_comb begin
        ar = {r_bi.left[CoordW-1], r_bi.left} + $signed({2'b0, r_bi.width});
        ab = {r_bi.top[CoordW-1], r_bi.top} + $signed({2'b0, r_bi.height});
        br = {r_rd.left[CoordW-1], r_rd.left} + $signed({2'b0, r_rd.width});
        bb = {r_rd.top[CoordW-1], r_rd.top} + $signed({2'b0, r_rd.height});
        x0 = (r_bi.left > r_rd.left) ? {r_bi.left[CoordW-1], r_bi.left}
                                     : {r_rd.left[CoordW-1], r_rd.left};
        y0 = (r_bi.top > r_rd.top) ? {r_bi.top[CoordW-1], r_bi.top}
                                   : {r_rd.top[CoordW-1], r_rd.top};
        x1 = (ar < br) ? ar : br;
        y1 = (ab < bb) ? ab : bb;
        dx = {x1[CoordW], x1} - {x0[CoordW], x0};
        dy = {y1[CoordW], y1} - {y0[CoordW], y0};
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = r_k[AW-1:0];
        wr_data = r_item;
        case (r_state)
            S_INS: begin
                if (r_k != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_k - 1'b1);
                end else begin
                    we = 1'b1;
                end
            end
            S_INS2: begin
                we = 1'b1;
                if (r_rd.score < r_item.score) begin
                    wr_data = r_rd;
                end
            end
            S_OI: begin
                rd_en   = 1'b1;
                rd_addr = r_i[AW-1:0];
            end
            S_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = r_j[AW-1:0];
            end
            S_ERD: begin
                rd_en   = 1'b1;
                rd_addr = r_i[AW-1:0];
            end
            default: ;
        endcase
    end

    assign s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= cabn_pkg::ThrReset;
            r_count  <= '0;
            r_supp   <= '0;
            r_ovf    <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_item      <= cabn_pkg::t_box'(s_tdata[cabn_pkg::BoxW-1:0]);
                        r_item_last <= s_tlast;
                        r_k         <= r_count;
                        r_i         <= '0;
                        if (r_count < CW'(MAX_BOXES)) begin
                            r_state <= S_INS;
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= s_tlast ? S_OI : S_IDLE;
                        end
                    end
                end
                S_INS: begin
                    if (r_k == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_item_last ? S_OI : S_IDLE;
                    end else begin
                        r_state <= S_INS2;
                    end
                end
                S_INS2: begin
                    if (r_rd.score < r_item.score) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_INS;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_item_last ? S_OI : S_IDLE;
                    end
                end
                S_OI: begin
                    if (r_i >= r_count) begin
                        r_i     <= '0;
                        r_state <= S_ERD;
                    end else if (r_supp[r_i[AW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_last  <= r_i;
                        r_state <= S_LOADI;
                    end
                end
                S_LOADI: begin
                    r_bi    <= r_rd;
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_area_a <= r_bi.width * r_bi.height;
                    r_j      <= r_i + 1'b1;
                    r_state  <= S_RDJ;
                end
                S_RDJ: begin
                    if (r_j >= r_count) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_OI;
                    end else begin
                        r_state <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    if (r_rd.class_id != r_bi.class_id || r_supp[r_j[AW-1:0]]) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end else begin
                        r_hit   <= (dx > 0) && (dy > 0);
                        r_dx    <= dx[SizeW:0];
                        r_dy    <= dy[SizeW:0];
                        r_bw    <= r_rd.width;
                        r_bh    <= r_rd.height;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_inter  <= r_hit ? AreaW'(r_dx[SizeW-1:0] * r_dy[SizeW-1:0]) : '0;
                    r_area_b <= r_bw * r_bh;
                    r_state  <= S_UNI;
                end
                S_UNI: begin
                    r_union <= {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
                    r_state <= S_THR;
                end
                S_THR: begin
                    r_prod  <= r_thr * r_union;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // intersection * 256 > threshold * union
                    if ({2'b0, r_inter, 8'b0} > r_prod) begin
                        r_supp[r_j[AW-1:0]] <= 1'b1;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= S_RDJ;
                end
                S_ERD: begin
                    if (r_i >= r_count) begin
                        r_count <= '0;
                        r_supp  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    if (r_supp[r_i[AW-1:0]]) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ERD;
                    end else begin
                        m_tdata  <= {{(cabn_pkg::DataW - cabn_pkg::BoxW){1'b0}}, r_rd};
                        m_tlast  <= (r_i == r_last);
                        m_tuser  <= r_ovf;
                        m_tvalid <= 1'b1;
                        r_state  <= S_EWAIT;
                    end
                end
                S_EWAIT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        r_i      <= r_i + 1'b1;
                        r_state  <= S_ERD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
